// ===== rtl/ring_neighbor_resource_arbiter_unit_defines.svh =====
// assertion macros used by the ring neighbor resource arbiter rtl
`ifndef RING_NEIGHBOR_RESOURCE_ARBITER_UNIT_DEFINES_SVH
`define RING_NEIGHBOR_RESOURCE_ARBITER_UNIT_DEFINES_SVH

// same-cycle implication
`define RNRA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rnra same-cycle check failed");

// next-cycle implication
`define RNRA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rnra next-cycle check failed");

`endif

// ===== rtl/rnra_pkg.sv =====
// types and constants of the ring neighbor resource arbiter
`timescale 1ns / 1ps

package rnra_pkg;

   localparam int SEAT_W = 6;
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      SEAT_THINKING = 2'd0,
      SEAT_HUNGRY   = 2'd1,
      SEAT_EATING   = 2'd2
   } seat_state_type;

   typedef enum logic [1:0] {
      SEL_A = 2'd0,
      SEL_B = 2'd1,
      SEL_C = 2'd2
   } operand_sel_type;

   typedef enum logic [2:0] {
      CTRL_CLEAR,
      CTRL_IDLE,
      CTRL_SETUP,
      CTRL_RD_A,
      CTRL_RD_B,
      CTRL_RD_C,
      CTRL_EVAL,
      CTRL_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic            load;
      logic            clear_wr;
      logic            setup_wr;
      operand_sel_type rd_sel;
      logic            cap_a;
      logic            cap_b;
      logic            eval;
      logic            next_test;
   } ctrl_cmd_type;

   typedef struct packed {
      logic id_err;
      logic putdown;
      logic phase;
      logic clear_last;
   } ctrl_status_type;

endpackage

// ===== rtl/rnra_datapath.sv =====
// seat state memory, neighbor index logic and grant evaluation
`timescale 1ns / 1ps

module rnra_datapath #(
   parameter int MAX_SEATS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rnra_pkg::ctrl_cmd_type        cmd,
   output rnra_pkg::ctrl_status_type     status,
   input  logic                          req_type,
   input  logic [rnra_pkg::SEAT_W-1:0]   req_seat_id,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rnra_pkg::COUNT_W-1:0]  csr_seat_count,
   output logic                          rsp_self_granted,
   output logic                          rsp_left_granted,
   output logic                          rsp_right_granted,
   output logic [rnra_pkg::SEAT_W-1:0]   rsp_left_seat,
   output logic [rnra_pkg::SEAT_W-1:0]   rsp_right_seat,
   output logic                          rsp_id_error
);
   import rnra_pkg::*;

   localparam int IDX_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int NW = $clog2(MAX_SEATS + 1);
   localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
   localparam logic [CW-1:0] N_MIN = CW'(2);
   localparam logic [CW-1:0] N_MAX = CW'(MAX_SEATS);
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_SEATS - 1);

   function automatic logic [IDX_W-1:0] left_of(input logic [IDX_W-1:0] x,
                                                input logic [CW-1:0] cnt);
      left_of = (x == '0) ? IDX_W'(cnt - CW'(1)) : x - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] right_of(input logic [IDX_W-1:0] x,
                                                 input logic [CW-1:0] cnt);
      logic [CW-1:0] nx;
      nx = CW'(x) + CW'(1);
      right_of = (nx >= cnt) ? '0 : IDX_W'(nx);
   endfunction

   seat_state_type seat_mem [MAX_SEATS];

   logic [COUNT_W-1:0] seat_count_ff, seat_count_in;
   logic               type_ff, type_in;
   logic [SEAT_W-1:0]  id_ff, id_in;
   logic               phase_ff, phase_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   seat_state_type     a_ff, a_in;
   seat_state_type     b_ff, b_in;
   seat_state_type     rdata_ff;
   logic               self_ff, self_in;
   logic               left_ff, left_in;
   logic               right_ff, right_in;

   logic [CW-1:0]      cnt_w;
   logic [CW-1:0]      n;
   logic [CW-1:0]      id_w;
   logic               id_err;
   logic [IDX_W-1:0]   id_ix, l, r, ll, rr;
   logic [IDX_W-1:0]   ta, tb, tc;
   logic [IDX_W-1:0]   rd_addr;
   logic               grant;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   seat_state_type     wr_data;

   // effective seat count, saturated to 2..MAX_SEATS
   always_comb begin
      cnt_w = CW'(seat_count_ff);
      if (cnt_w < N_MIN) begin
         n = N_MIN;
      end else if (cnt_w > N_MAX) begin
         n = N_MAX;
      end else begin
         n = cnt_w;
      end
   end

   assign id_w   = CW'(id_ff);
   assign id_err = (id_w >= n);
   assign id_ix  = IDX_W'(id_w);
   assign l      = left_of(id_ix, n);
   assign r      = right_of(id_ix, n);
   assign ll     = left_of(l, n);
   assign rr     = right_of(r, n);

   // seat under test and its two neighbors
   always_comb begin
      if (!type_ff) begin
         ta = id_ix;
         tb = l;
         tc = r;
      end else if (!phase_ff) begin
         ta = l;
         tb = ll;
         tc = id_ix;
      end else begin
         ta = r;
         tb = id_ix;
         tc = rr;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         SEL_A:   rd_addr = ta;
         SEL_B:   rd_addr = tb;
         SEL_C:   rd_addr = tc;
         default: rd_addr = ta;
      endcase
   end

   assign grant = (a_ff == SEAT_HUNGRY) && (b_ff != SEAT_EATING) &&
                  (rdata_ff != SEAT_EATING);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = SEAT_THINKING;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.setup_wr) begin
         wr_en   = 1'b1;
         wr_addr = id_ix;
         wr_data = type_ff ? SEAT_THINKING : SEAT_HUNGRY;
      end else if (cmd.eval && grant) begin
         wr_en   = 1'b1;
         wr_addr = ta;
         wr_data = SEAT_EATING;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seat_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= seat_mem[rd_addr];
   end

   assign csr_ready = 1'b1;

   always_comb begin
      seat_count_in = seat_count_ff;
      type_in       = type_ff;
      id_in         = id_ff;
      phase_in      = phase_ff;
      clr_in        = clr_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      self_in       = self_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      if (csr_valid && csr_ready) begin
         seat_count_in = csr_seat_count;
      end
      if (cmd.clear_wr) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (cmd.load) begin
         type_in  = req_type;
         id_in    = req_seat_id;
         phase_in = 1'b0;
         self_in  = 1'b0;
         left_in  = 1'b0;
         right_in = 1'b0;
      end
      if (cmd.next_test) begin
         phase_in = 1'b1;
      end
      if (cmd.cap_a) begin
         a_in = rdata_ff;
      end
      if (cmd.cap_b) begin
         b_in = rdata_ff;
      end
      if (cmd.eval) begin
         if (!type_ff) begin
            self_in = grant;
         end else if (!phase_ff) begin
            left_in = grant;
         end else begin
            right_in = grant;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seat_count_ff <= COUNT_RESET;
         phase_ff      <= 1'b0;
         clr_ff        <= '0;
      end else begin
         seat_count_ff <= seat_count_in;
         phase_ff      <= phase_in;
         clr_ff        <= clr_in;
      end
      type_ff  <= type_in;
      id_ff    <= id_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      self_ff  <= self_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign status.id_err     = id_err;
   assign status.putdown    = type_ff;
   assign status.phase      = phase_ff;
   assign status.clear_last = (clr_ff == CLR_LAST);

   assign rsp_self_granted  = self_ff;
   assign rsp_left_granted  = left_ff;
   assign rsp_right_granted = right_ff;
   assign rsp_left_seat     = id_err ? '0 : SEAT_W'(l);
   assign rsp_right_seat    = id_err ? '0 : SEAT_W'(r);
   assign rsp_id_error      = id_err;

endmodule

// ===== rtl/rnra_ctrl.sv =====
// sequencing state machine of the ring neighbor resource arbiter
`timescale 1ns / 1ps
`include "ring_neighbor_resource_arbiter_unit_defines.svh"

module rnra_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output logic                      rsp_valid,
   output rnra_pkg::ctrl_cmd_type    cmd,
   input  rnra_pkg::ctrl_status_type status
);
   import rnra_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = SEL_A;
      rsp_valid = 1'b0;
      busy      = 1'b1;
      case (state_ff)
         CTRL_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = CTRL_IDLE;
            end
         end
         CTRL_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = CTRL_SETUP;
            end
         end
         CTRL_SETUP: begin
            if (status.id_err) begin
               state_in = CTRL_DONE;
            end else begin
               cmd.setup_wr = 1'b1;
               state_in     = CTRL_RD_A;
            end
         end
         CTRL_RD_A: begin
            cmd.rd_sel = SEL_A;
            state_in   = CTRL_RD_B;
         end
         CTRL_RD_B: begin
            cmd.rd_sel = SEL_B;
            cmd.cap_a  = 1'b1;
            state_in   = CTRL_RD_C;
         end
         CTRL_RD_C: begin
            cmd.rd_sel = SEL_C;
            cmd.cap_b  = 1'b1;
            state_in   = CTRL_EVAL;
         end
         CTRL_EVAL: begin
            cmd.eval = 1'b1;
            if (status.putdown && !status.phase) begin
               cmd.next_test = 1'b1;
               state_in      = CTRL_RD_A;
            end else begin
               state_in = CTRL_DONE;
            end
         end
         CTRL_DONE: begin
            rsp_valid = 1'b1;
            state_in  = CTRL_IDLE;
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   `RNRA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `RNRA_ASSERT_NXT(a_rsp_then_idle, clock, reset, rsp_valid, !busy && !rsp_valid)
   `RNRA_ASSERT_IMP(a_setup_valid_id, clock, reset, cmd.setup_wr, !status.id_err)
   `RNRA_ASSERT_IMP(a_second_test, clock, reset, cmd.next_test,
                    status.putdown && !status.phase)

endmodule

// ===== rtl/ring_neighbor_resource_arbiter_unit.sv =====
// top level of the ring neighbor resource arbiter
`timescale 1ns / 1ps
// Arbitrates a ring of seats; each seat is thinking, hungry or eating.
// Request channel: req_type (0 pickup, 1 putdown) and req_seat_id are taken
// at a clock edge with start high and busy low. busy stays high until the
// result word has been shown.
// Result channel: one word per request, held for exactly one cycle while
// rsp_valid is high. The receiver cannot stall; the word must be taken then.
// Sequence after accept: SETUP, RD_A, RD_B, RD_C, EVAL, DONE for a pickup;
// a putdown runs RD_A to EVAL twice, and an out-of-range seat id goes from
// SETUP straight to DONE. The next request may be accepted in the cycle
// after rsp_valid. The steps come from the single-port seat state memory:
// each grant test reads the seat and its two neighbors one per cycle, then writes.
// csr channel: csr_seat_count is written whenever csr_valid is high
// (csr_ready is always high); write it only while busy is low.
// Reset: seat count returns to 64 and every seat is cleared to thinking by a
// sweep of all MAX_SEATS entries, one entry per cycle, with busy held high.
module ring_neighbor_resource_arbiter_unit #(
   parameter int MAX_SEATS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [rnra_pkg::SEAT_W-1:0]   req_seat_id,
   output logic                          rsp_valid,
   output logic                          rsp_self_granted,
   output logic                          rsp_left_granted,
   output logic                          rsp_right_granted,
   output logic [rnra_pkg::SEAT_W-1:0]   rsp_left_seat,
   output logic [rnra_pkg::SEAT_W-1:0]   rsp_right_seat,
   output logic                          rsp_id_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rnra_pkg::COUNT_W-1:0]  csr_seat_count
);
   import rnra_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   rnra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   rnra_datapath #(
      .MAX_SEATS (MAX_SEATS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_seat_id       (req_seat_id),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_seat_count    (csr_seat_count),
      .rsp_self_granted  (rsp_self_granted),
      .rsp_left_granted  (rsp_left_granted),
      .rsp_right_granted (rsp_right_granted),
      .rsp_left_seat     (rsp_left_seat),
      .rsp_right_seat    (rsp_right_seat),
      .rsp_id_error      (rsp_id_error)
   );

endmodule
